// ===== src/assert_macros.svh =====
// Assertion macros shared by the attitude update RTL.
// Needs signals clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== src/dqa_pkg.sv =====
// Shared types, constants and helper functions of the attitude update block.
// No dependencies; imported by every module of the block.
`default_nettype none
package dqa_pkg;

	// Quaternion format Q2.QFRAC and CORDIC length
	localparam int QUAT_WIDTH    = 32;
	localparam int QFRAC         = QUAT_WIDTH - 2;
	localparam int CORDIC_STAGES = 24;

	// Internal widths
	localparam int RM_W  = 18;  // signed remapped offset, magnitude up to 65536
	localparam int OP_W  = 34;  // signed multiplier operand
	localparam int MAG_W = 33;  // operand magnitude
	localparam int RES_W = 52;  // signed multiplier result after shift
	localparam int ANG_W = 36;  // signed half angle residue, Q.30
	localparam int CRD_W = 34;  // signed CORDIC x/y, Q.30
	localparam int IDX_W = 5;   // CORDIC step index

	typedef logic signed [QUAT_WIDTH-1:0] quat_t;

	localparam longint Q_LIM = 64'sd1 <<< (QFRAC + 1);
	localparam quat_t  Q_ONE_Q = quat_t'(64'sd1 <<< QFRAC);
	localparam logic signed [OP_W-1:0] THREE_ONE = OP_W'(3 * (64'sd1 <<< QFRAC));

	localparam logic signed [CRD_W-1:0] CRD_START = CRD_W'(64'sd652032874);
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(64'sd843314857);
	localparam logic signed [ANG_W-1:0] HALF_PI = ANG_W'(64'sd1686629713);

	// Register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_DEAD_ZONE = 2'd0,
		REG_YAW_RATE  = 2'd1,
		REG_PITCH_RATE = 2'd2
	} reg_idx_t;

	// Product shift codes of the shared multiplier
	typedef enum logic [1:0] {
		SH_0  = 2'd0,
		SH_Q  = 2'd1,
		SH_Q1 = 2'd2
	} shift_t;

	// Classified request passed from front to back
	typedef struct packed {
		logic signed [RM_W-1:0] rm_x;
		logic signed [RM_W-1:0] rm_y;
		logic [15:0]            dt;
	} cmd_t;

	// Saturate to the Q2.QFRAC range
	function automatic quat_t sat_q(input logic signed [RES_W-1:0] v);
		logic signed [RES_W-1:0] hi;
		logic signed [RES_W-1:0] lo;
		hi = RES_W'(Q_LIM - 64'sd1);
		lo = RES_W'(-Q_LIM);
		if (v > hi) begin
			return hi[QUAT_WIDTH-1:0];
		end else if (v < lo) begin
			return lo[QUAT_WIDTH-1:0];
		end
		return v[QUAT_WIDTH-1:0];
	endfunction

	// atan(2^-i) in Q.30
	function automatic logic [31:0] atan_q30(input logic [IDX_W-1:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:  v = 32'd843314856;
			5'd1:  v = 32'd497837829;
			5'd2:  v = 32'd263043836;
			5'd3:  v = 32'd133525158;
			5'd4:  v = 32'd67021686;
			5'd5:  v = 32'd33543515;
			5'd6:  v = 32'd16775850;
			5'd7:  v = 32'd8388437;
			5'd8:  v = 32'd4194282;
			5'd9:  v = 32'd2097149;
			5'd10: v = 32'd1048575;
			5'd11: v = 32'd524287;
			5'd12: v = 32'd262143;
			5'd13: v = 32'd131071;
			5'd14: v = 32'd65535;
			5'd15: v = 32'd32767;
			5'd16: v = 32'd16383;
			5'd17: v = 32'd8191;
			5'd18: v = 32'd4095;
			5'd19: v = 32'd2047;
			5'd20: v = 32'd1023;
			5'd21: v = 32'd511;
			5'd22: v = 32'd255;
			5'd23: v = 32'd127;
			5'd24: v = 32'd63;
			5'd25: v = 32'd31;
			5'd26: v = 32'd15;
			5'd27: v = 32'd8;
			5'd28: v = 32'd4;
			5'd29: v = 32'd2;
			5'd30: v = 32'd1;
			5'd31: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== src/deadzone_quaternion_attitude_update_core.sv =====
// Top level of the dead zone aim to quaternion attitude update block.
// Uses dqa_pkg, dqa_front, dqa_queue and dqa_back; holds the config registers.
`default_nettype none
// Each request carries a two-axis aim offset and a time step; the block
// remaps both offsets through the dead zone, turns them into yaw and pitch
// half angles, rotates the stored orientation quaternion by them and
// renormalizes it, and delivers the new quaternion as one result. The front
// end runs its serial remap divider on each axis in turn (17 steps plus a
// finish step) and takes no new request until it has handed the last one
// to the queue; it holds up to one request while a two-entry queue holds
// two more. The back end's work is set by the shared 33x33 multiplier (37
// products, each issued and then consumed) and the 24-step CORDIC per
// axis, with at most five quarter-turn reductions per axis before CORDIC; a
// zero angle skips reduction and CORDIC. A finished quaternion waits in the
// result register while the next request proceeds.
// Registers: 0x0 dead zone half width, 0x4 yaw_rate_max, 0x8 pitch_rate_max.
module deadzone_quaternion_attitude_update_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic signed [15:0]  offset_x,
	input  logic signed [15:0]  offset_y,
	input  logic [15:0]         step_time,
	output logic                empty,
	input  logic                pop,
	output logic signed [31:0]  quat_w,
	output logic signed [31:0]  quat_x,
	output logic signed [31:0]  quat_y,
	output logic signed [31:0]  quat_z,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import dqa_pkg::*;

	logic [15:0] dz_q;
	logic [15:0] yaw_q;
	logic [15:0] pitch_q;
	logic        cfg_wr;
	reg_idx_t    cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q    <= 16'd3277;
			yaw_q   <= 16'd8192;
			pitch_q <= 16'd8192;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_DEAD_ZONE:  dz_q    <= pwdata[15:0];
				REG_YAW_RATE:   yaw_q   <= pwdata[15:0];
				REG_PITCH_RATE: pitch_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register read back
	always_comb begin
		unique case (cfg_idx)
			REG_DEAD_ZONE:  prdata = {16'd0, dz_q};
			REG_YAW_RATE:   prdata = {16'd0, yaw_q};
			REG_PITCH_RATE: prdata = {16'd0, pitch_q};
			default:        prdata = '0;
		endcase
	end

	cmd_t  f_cmd;
	logic  f_valid;
	logic  qu_full;
	cmd_t  b_cmd;
	logic  qu_empty;
	logic  b_take;
	logic  b_valid;
	quat_t b_w;
	quat_t b_x;
	quat_t b_y;
	quat_t b_z;

	dqa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.offset_x  (offset_x),
		.offset_y  (offset_y),
		.step_time (step_time),
		.dz_width  (dz_q),
		.cmd_valid (f_valid),
		.cmd       (f_cmd),
		.cmd_ready (!qu_full)
	);

	dqa_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_valid),
		.wr_data (f_cmd),
		.full    (qu_full),
		.rd_en   (b_take),
		.rd_data (b_cmd),
		.empty   (qu_empty)
	);

	dqa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (!qu_empty),
		.cmd        (b_cmd),
		.cmd_take   (b_take),
		.yaw_rate   (yaw_q),
		.pitch_rate (pitch_q),
		.res_valid  (b_valid),
		.res_pop    (pop),
		.quat_w     (b_w),
		.quat_x     (b_x),
		.quat_y     (b_y),
		.quat_z     (b_z)
	);

	assign empty  = !b_valid;
	assign quat_w = b_w;
	assign quat_x = b_x;
	assign quat_y = b_y;
	assign quat_z = b_z;

endmodule
`default_nettype wire

// ===== src/dqa_front.sv =====
// Front end: takes an aim request and runs the dead zone remap of both axes.
// Uses dqa_pkg; one serial restoring divider shared by the two axes.
`default_nettype none
module dqa_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic signed [15:0]  offset_x,
	input  logic signed [15:0]  offset_y,
	input  logic [15:0]         step_time,
	input  logic [15:0]         dz_width,
	output logic                cmd_valid,
	output dqa_pkg::cmd_t       cmd,
	input  logic                cmd_ready
);
	import dqa_pkg::*;

	localparam int DIV_STEPS = RM_W - 1;
	localparam logic [16:0] FULL_T = 17'h10000;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fst_t;

	fst_t                   state_q;
	logic                   ax_q;
	logic signed [15:0]     oy_q;
	logic [15:0]            dt_q;
	logic signed [RM_W-1:0] rmx_q;
	logic signed [RM_W-1:0] rmy_q;
	logic [4:0]             cnt_q;
	logic [16:0]            rem_q;
	logic [16:0]            quo_q;
	logic [16:0]            nb_q;
	logic [16:0]            dv_q;
	logic                   zero_q;
	logic                   big_q;
	logic                   neg_q;

	// Division setup for the axis about to start
	logic signed [15:0] off_sel;
	logic signed [16:0] off_ext;
	logic [16:0]        mag17;
	logic [16:0]        a16;
	logic [16:0]        dz17;
	logic               s_zero;
	logic [16:0]        s_diff;
	logic [16:0]        s_dv;
	logic               s_big;

	assign off_sel = (state_q == F_IDLE) ? offset_x : oy_q;
	assign off_ext = 17'(off_sel);
	assign mag17   = off_ext[16] ? 17'(-off_ext) : 17'(off_ext);
	assign a16     = {mag17[15:0], 1'b0};
	assign dz17    = {1'b0, dz_width};
	assign s_zero  = (a16 <= dz17);
	assign s_diff  = a16 - dz17;
	assign s_dv    = FULL_T - dz17;
	assign s_big   = ({1'b0, s_diff} >= {s_dv, 1'b0});

	// One restoring step
	logic [17:0] sh;
	logic        ge;
	logic [17:0] sh_sub;
	assign sh     = {rem_q, nb_q[16]};
	assign ge     = (sh >= {1'b0, dv_q});
	assign sh_sub = sh - {1'b0, dv_q};

	// Clamp and sign
	logic [16:0]            t17;
	logic signed [RM_W-1:0] tpos;
	logic signed [RM_W-1:0] rm_fin;
	assign t17    = (big_q || quo_q > FULL_T) ? FULL_T : quo_q;
	assign tpos   = RM_W'(t17);
	assign rm_fin = zero_q ? '0 : (neg_q ? -tpos : tpos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			ax_q    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (push) begin
						oy_q    <= offset_y;
						dt_q    <= step_time;
						ax_q    <= 1'b0;
						zero_q  <= s_zero;
						big_q   <= s_big;
						neg_q   <= off_sel[15];
						dv_q    <= s_dv;
						rem_q   <= {1'b0, s_diff[16:1]};
						nb_q    <= {s_diff[0], 16'b0};
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					if (cnt_q == 5'(DIV_STEPS)) begin
						if (!ax_q) begin
							rmx_q  <= rm_fin;
							ax_q   <= 1'b1;
							zero_q <= s_zero;
							big_q  <= s_big;
							neg_q  <= off_sel[15];
							dv_q   <= s_dv;
							rem_q  <= {1'b0, s_diff[16:1]};
							nb_q   <= {s_diff[0], 16'b0};
							quo_q  <= '0;
							cnt_q  <= '0;
						end else begin
							rmy_q   <= rm_fin;
							state_q <= F_PUSH;
						end
					end else begin
						rem_q <= ge ? sh_sub[16:0] : sh[16:0];
						quo_q <= {quo_q[15:0], ge};
						nb_q  <= {nb_q[15:0], 1'b0};
						cnt_q <= cnt_q + 5'd1;
					end
				end
				F_PUSH: begin
					if (cmd_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign full      = (state_q != F_IDLE);
	assign cmd_valid = (state_q == F_PUSH);
	assign cmd.rm_x  = rmx_q;
	assign cmd.rm_y  = rmy_q;
	assign cmd.dt    = dt_q;

endmodule
`default_nettype wire

// ===== src/dqa_queue.sv =====
// Two-entry request queue between the front end and the back end.
// Uses dqa_pkg for the request type.
`default_nettype none
module dqa_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  dqa_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output dqa_pkg::cmd_t rd_data,
	output logic          empty
);
	import dqa_pkg::*;

	cmd_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rp_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wp_q <= ~wp_q;
			end
			if (do_rd) begin
				rp_q <= ~rp_q;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

// ===== src/dqa_mul.sv =====
// Shared signed multiplier: exact product of magnitudes, registered, then a
// truncating right shift and the sign. Uses dqa_pkg.
`default_nettype none
module dqa_mul (
	input  logic                             clk,
	input  logic signed [dqa_pkg::OP_W-1:0]  a,
	input  logic signed [dqa_pkg::OP_W-1:0]  b,
	input  dqa_pkg::shift_t                  sh,
	output logic signed [dqa_pkg::RES_W-1:0] res
);
	import dqa_pkg::*;

	logic [MAG_W-1:0]   am;
	logic [MAG_W-1:0]   bm;
	logic [2*MAG_W-1:0] prod_s1;
	logic               neg_s1;
	shift_t             sh_s1;
	logic [2*MAG_W-1:0] shd;
	logic signed [RES_W-1:0] mag;

	assign am = a[OP_W-1] ? MAG_W'(-a) : MAG_W'(a);
	assign bm = b[OP_W-1] ? MAG_W'(-b) : MAG_W'(b);

	// Product register
	always_ff @(posedge clk) begin
		prod_s1 <= am * bm;
		neg_s1  <= a[OP_W-1] ^ b[OP_W-1];
		sh_s1   <= sh;
	end

	// Shift toward zero and apply sign
	always_comb begin
		unique case (sh_s1)
			SH_0:    shd = prod_s1;
			SH_Q:    shd = prod_s1 >> QFRAC;
			SH_Q1:   shd = prod_s1 >> (QFRAC + 1);
			default: shd = prod_s1;
		endcase
		mag = shd[RES_W-1:0];
		res = neg_s1 ? -mag : mag;
	end

endmodule
`default_nettype wire

// ===== src/dqa_back.sv =====
// Back end: half angles, CORDIC, quaternion products, Newton normalization
// and the result register. Uses dqa_pkg, dqa_mul and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module dqa_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  dqa_pkg::cmd_t  cmd,
	output logic           cmd_take,
	input  logic [15:0]    yaw_rate,
	input  logic [15:0]    pitch_rate,
	output logic           res_valid,
	input  logic           res_pop,
	output dqa_pkg::quat_t quat_w,
	output dqa_pkg::quat_t quat_x,
	output dqa_pkg::quat_t quat_y,
	output dqa_pkg::quat_t quat_z
);
	import dqa_pkg::*;

	typedef enum logic [9:0] {
		B_IDLE  = 10'b0000000001,
		B_ANG   = 10'b0000000010,
		B_RED   = 10'b0000000100,
		B_CORD  = 10'b0000001000,
		B_TRIG  = 10'b0000010000,
		B_ROT   = 10'b0000100000,
		B_NORM  = 10'b0001000000,
		B_NEWT  = 10'b0010000000,
		B_SCALE = 10'b0100000000,
		B_DONE  = 10'b1000000000
	} bst_t;

	bst_t                    state_q;
	logic [3:0]              op_q;
	logic                    ph_q;
	logic                    axis_q;
	logic [1:0]              rd_q;
	cmd_t                    cmd_q;
	logic signed [RES_W-1:0] p_q;
	logic signed [RES_W-1:0] acc_q;
	logic signed [ANG_W-1:0] r_q;
	logic [1:0]              quad_q;
	logic                    neg_q;
	logic signed [CRD_W-1:0] cx_q;
	logic signed [CRD_W-1:0] cy_q;
	logic [IDX_W-1:0]        ci_q;
	quat_t                   c_q;
	quat_t                   s_q;
	quat_t                   n2_q;
	quat_t                   inv_q;
	quat_t                   t_q;
	quat_t                   q_q [4];
	quat_t                   n_q [4];
	logic                    ov_q;
	quat_t                   ow_q;
	quat_t                   ox_q;
	quat_t                   oy_q;
	quat_t                   oz_q;

	// Rotation term table: {subtract, use sin, source index}
	function automatic logic [3:0] rot_code(input logic ax, input logic [2:0] op);
		logic [3:0] v;
		unique case ({ax, op})
			4'd0:  v = {1'b0, 1'b0, 2'd0};
			4'd1:  v = {1'b1, 1'b1, 2'd2};
			4'd2:  v = {1'b0, 1'b0, 2'd1};
			4'd3:  v = {1'b1, 1'b1, 2'd3};
			4'd4:  v = {1'b0, 1'b1, 2'd0};
			4'd5:  v = {1'b0, 1'b0, 2'd2};
			4'd6:  v = {1'b0, 1'b1, 2'd1};
			4'd7:  v = {1'b0, 1'b0, 2'd3};
			4'd8:  v = {1'b0, 1'b0, 2'd0};
			4'd9:  v = {1'b1, 1'b1, 2'd1};
			4'd10: v = {1'b0, 1'b1, 2'd0};
			4'd11: v = {1'b0, 1'b0, 2'd1};
			4'd12: v = {1'b0, 1'b0, 2'd2};
			4'd13: v = {1'b0, 1'b1, 2'd3};
			4'd14: v = {1'b0, 1'b0, 2'd3};
			4'd15: v = {1'b1, 1'b1, 2'd2};
		endcase
		return v;
	endfunction

	// Operand selection for the shared multiplier
	logic signed [RM_W-1:0]  rm_cur;
	logic [RM_W-1:0]         rm_mag;
	logic [15:0]             rate_cur;
	logic [3:0]              rc;
	quat_t                   src [4];
	logic signed [OP_W-1:0]  tm;
	logic signed [OP_W-1:0]  ma;
	logic signed [OP_W-1:0]  mb;
	shift_t                  msh;
	logic signed [RES_W-1:0] mres;
	logic signed [RES_W-1:0] rsum;
	logic [ANG_W-1:0]        ang;

	assign rm_cur   = axis_q ? cmd_q.rm_y : cmd_q.rm_x;
	assign rm_mag   = rm_cur[RM_W-1] ? RM_W'(-rm_cur) : RM_W'(rm_cur);
	assign rate_cur = axis_q ? pitch_rate : yaw_rate;
	assign rc       = rot_code(axis_q, op_q[2:0]);
	assign tm       = THREE_ONE - OP_W'(t_q);
	assign rsum     = rc[3] ? (acc_q - mres) : (acc_q + mres);
	assign ang      = mres[ANG_W+14:15];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			src[k] = axis_q ? n_q[k] : q_q[k];
		end
	end

	always_comb begin
		ma  = '0;
		mb  = '0;
		msh = SH_Q;
		unique case (state_q)
			B_ANG: begin
				msh = SH_0;
				if (op_q == 4'd0) begin
					ma = OP_W'(rm_mag);
					mb = OP_W'(rate_cur);
				end else begin
					ma = p_q[OP_W-1:0];
					mb = OP_W'(cmd_q.dt);
				end
			end
			B_ROT: begin
				ma = OP_W'(src[rc[1:0]]);
				mb = rc[2] ? OP_W'(s_q) : OP_W'(c_q);
			end
			B_NORM: begin
				ma = OP_W'(q_q[op_q[1:0]]);
				mb = OP_W'(q_q[op_q[1:0]]);
			end
			B_NEWT: begin
				case (op_q[1:0])
					2'd0: begin
						ma = OP_W'(inv_q);
						mb = OP_W'(inv_q);
					end
					2'd1: begin
						ma = OP_W'(n2_q);
						mb = OP_W'(t_q);
					end
					default: begin
						ma  = OP_W'(inv_q);
						mb  = tm;
						msh = SH_Q1;
					end
				endcase
			end
			B_SCALE: begin
				ma = OP_W'(q_q[op_q[1:0]]);
				mb = OP_W'(inv_q);
			end
			default: begin
				ma = '0;
			end
		endcase
	end

	dqa_mul u_mul (
		.clk (clk),
		.a   (ma),
		.b   (mb),
		.sh  (msh),
		.res (mres)
	);

	// CORDIC step and quadrant fix-up
	logic signed [CRD_W-1:0] dx;
	logic signed [CRD_W-1:0] dy;
	logic signed [ANG_W-1:0] at_s;
	logic signed [CRD_W-1:0] cxf;
	logic signed [CRD_W-1:0] syf;

	assign dx   = cy_q >>> ci_q;
	assign dy   = cx_q >>> ci_q;
	assign at_s = ANG_W'(atan_q30(ci_q));

	always_comb begin
		case (quad_q)
			2'd0: begin
				cxf = cx_q;
				syf = cy_q;
			end
			2'd1: begin
				cxf = -cy_q;
				syf = cx_q;
			end
			2'd2: begin
				cxf = -cx_q;
				syf = -cy_q;
			end
			default: begin
				cxf = cy_q;
				syf = -cx_q;
			end
		endcase
		if (neg_q) begin
			syf = -syf;
		end
	end

	// Sequencer: each product is issued, then consumed from the multiplier register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			op_q    <= '0;
			ph_q    <= 1'b0;
			axis_q  <= 1'b0;
			rd_q    <= '0;
			ov_q    <= 1'b0;
			q_q[0]  <= Q_ONE_Q;
			q_q[1]  <= '0;
			q_q[2]  <= '0;
			q_q[3]  <= '0;
		end else begin
			// a pop in the done state is handled by the reload below
			if (res_pop && ov_q && state_q != B_DONE) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						axis_q  <= 1'b0;
						op_q    <= '0;
						ph_q    <= 1'b0;
						state_q <= B_ANG;
					end
				end
				B_ANG: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (op_q == 4'd0) begin
							p_q  <= mres;
							op_q <= 4'd1;
						end else begin
							op_q   <= '0;
							r_q    <= ang;
							quad_q <= '0;
							neg_q  <= rm_cur[RM_W-1] ^ !axis_q;
							if (ang == '0) begin
								c_q     <= Q_ONE_Q;
								s_q     <= '0;
								state_q <= B_ROT;
							end else begin
								state_q <= B_RED;
							end
						end
					end
				end
				B_RED: begin
					if (r_q > QUARTER_TURN) begin
						r_q    <= r_q - HALF_PI;
						quad_q <= quad_q + 2'd1;
					end else begin
						cx_q    <= CRD_START;
						cy_q    <= '0;
						ci_q    <= '0;
						state_q <= B_CORD;
					end
				end
				B_CORD: begin
					if (r_q >= 0) begin
						cx_q <= cx_q - dx;
						cy_q <= cy_q + dy;
						r_q  <= r_q - at_s;
					end else begin
						cx_q <= cx_q + dx;
						cy_q <= cy_q - dy;
						r_q  <= r_q + at_s;
					end
					ci_q <= ci_q + IDX_W'(1);
					if (ci_q == IDX_W'(CORDIC_STAGES - 1)) begin
						state_q <= B_TRIG;
					end
				end
				B_TRIG: begin
					c_q     <= sat_q(RES_W'(cxf));
					s_q     <= sat_q(RES_W'(syf));
					op_q    <= '0;
					ph_q    <= 1'b0;
					state_q <= B_ROT;
				end
				B_ROT: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (!op_q[0]) begin
							acc_q <= mres;
						end else if (!axis_q) begin
							n_q[op_q[2:1]] <= sat_q(rsum);
						end else begin
							q_q[op_q[2:1]] <= sat_q(rsum);
						end
						if (op_q == 4'd7) begin
							op_q <= '0;
							if (!axis_q) begin
								axis_q  <= 1'b1;
								state_q <= B_ANG;
							end else begin
								state_q <= B_NORM;
							end
						end else begin
							op_q <= op_q + 4'd1;
						end
					end
				end
				B_NORM: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (op_q == 4'd0) begin
							acc_q <= mres;
							op_q  <= 4'd1;
						end else if (op_q == 4'd3) begin
							n2_q    <= sat_q(acc_q + mres);
							inv_q   <= Q_ONE_Q;
							rd_q    <= '0;
							op_q    <= '0;
							state_q <= B_NEWT;
						end else begin
							acc_q <= acc_q + mres;
							op_q  <= op_q + 4'd1;
						end
					end
				end
				B_NEWT: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						case (op_q[1:0])
							2'd0: begin
								t_q  <= sat_q(mres);
								op_q <= 4'd1;
							end
							2'd1: begin
								t_q  <= sat_q(mres);
								op_q <= 4'd2;
							end
							default: begin
								inv_q <= sat_q(mres);
								op_q  <= '0;
								if (rd_q == 2'd2) begin
									rd_q    <= '0;
									state_q <= B_SCALE;
								end else begin
									rd_q <= rd_q + 2'd1;
								end
							end
						endcase
					end
				end
				B_SCALE: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						q_q[op_q[1:0]] <= sat_q(mres);
						if (op_q == 4'd3) begin
							op_q    <= '0;
							state_q <= B_DONE;
						end else begin
							op_q <= op_q + 4'd1;
						end
					end
				end
				B_DONE: begin
					if (!ov_q || res_pop) begin
						ov_q    <= 1'b1;
						ow_q    <= q_q[0];
						ox_q    <= q_q[1];
						oy_q    <= q_q[2];
						oz_q    <= q_q[3];
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign cmd_take  = (state_q == B_IDLE);
	assign res_valid = ov_q;
	assign quat_w    = ow_q;
	assign quat_x    = ox_q;
	assign quat_y    = oy_q;
	assign quat_z    = oz_q;

	`ASSERT_NEXT(a_done_loads, state_q == B_DONE && (!ov_q || res_pop), ov_q && state_q == B_IDLE)
	`ASSERT_NEXT(a_result_holds, ov_q && !res_pop, ov_q && $stable(ow_q) && $stable(oz_q))
	`ASSERT_IMPL(a_newton_start, state_q == B_NEWT && rd_q == 2'd0 && op_q == 4'd0 && !ph_q, inv_q == Q_ONE_Q)
	`ASSERT_IMPL(a_cordic_index, state_q == B_CORD, ci_q <= IDX_W'(CORDIC_STAGES - 1))

endmodule
`default_nettype wire
